@@ src/rsl_pkg.sv @@
// Shared types and constants of the rectangle sector locator.
`default_nettype none

package rsl_pkg;

	localparam int DEF_MAX_SECTORS   = 64;
	localparam int DEF_MAX_NEIGHBORS = 8;
	localparam int QUEUE_DEPTH       = 2;

	localparam int COORD_W    = 32;
	localparam int IDX_W      = 6;
	localparam int SLOT_W     = 3;
	localparam int SCOUNT_W   = 7;
	localparam int NB_COUNT_W = 4;

	typedef enum logic [1:0] {
		OP_BOUNDS   = 2'd0,
		OP_NEIGHBOR = 2'd1,
		OP_LOCATE   = 2'd2,
		OP_FORGET   = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]                 opcode;
		logic [IDX_W-1:0]           sector_index;
		logic [SLOT_W-1:0]          neighbor_slot;
		logic                       neighbor_last;
		logic [IDX_W-1:0]           neighbor_index;
		logic signed [COORD_W-1:0]  x_low;
		logic signed [COORD_W-1:0]  y_low;
		logic signed [COORD_W-1:0]  x_high;
		logic signed [COORD_W-1:0]  y_high;
		logic signed [COORD_W-1:0]  pos_x;
		logic signed [COORD_W-1:0]  pos_y;
	} in_item_t;

	typedef struct packed {
		logic             sector_found;
		logic [IDX_W-1:0] found_index;
	} out_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_low;
		logic signed [COORD_W-1:0] y_low;
		logic signed [COORD_W-1:0] x_high;
		logic signed [COORD_W-1:0] y_high;
	} bounds_t;

	// One queued command. A locate carries its position in x_low and y_low of bnd.
	typedef struct packed {
		op_t               op;
		logic [IDX_W-1:0]  sector_index;
		logic [SLOT_W-1:0] slot;
		logic              last;
		logic [IDX_W-1:0]  neighbor_index;
		bounds_t           bnd;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CUR,
		ST_NB_RD,
		ST_NB_IDX,
		ST_NB_CMP,
		ST_ALL
	} back_state_t;

endpackage

`default_nettype wire

@@ src/rsl_front.sv @@
// Front end: decodes an accepted beat into a queued command and drops ignored loads.
`default_nettype none

module rsl_front import rsl_pkg::*; #(
	parameter int MAX_SECTORS   = DEF_MAX_SECTORS,
	parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS
) (
	input  wire in_item_t item,
	input  wire logic     take,
	output logic          push,
	output cmd_t          entry
);

	logic sector_ok;
	logic slot_ok;
	op_t  op;

	assign op        = op_t'(item.opcode);
	assign sector_ok = 32'(item.sector_index) < 32'(MAX_SECTORS);
	assign slot_ok   = 32'(item.neighbor_slot) < 32'(MAX_NEIGHBORS);

	always_comb begin
		entry.op             = op;
		entry.sector_index   = item.sector_index;
		entry.slot           = item.neighbor_slot;
		entry.last           = item.neighbor_last;
		entry.neighbor_index = item.neighbor_index;
		entry.bnd.x_low      = item.x_low;
		entry.bnd.y_low      = item.y_low;
		entry.bnd.x_high     = item.x_high;
		entry.bnd.y_high     = item.y_high;
		push                 = 1'b0;
		case (op)
			OP_BOUNDS: begin
				push = take && sector_ok;
			end
			OP_NEIGHBOR: begin
				push = take && sector_ok && slot_ok;
			end
			OP_LOCATE: begin
				entry.bnd.x_low = item.pos_x;
				entry.bnd.y_low = item.pos_y;
				push            = take;
			end
			default: begin
				push = take;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ src/rsl_queue.sv @@
// Short command queue between the front end and the back end.
`default_nettype none

module rsl_queue import rsl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wr_entry,
	input  wire logic pop,
	output cmd_t      head,
	output logic      full,
	output logic      empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	assign full  = fill_q == CNT_W'(QUEUE_DEPTH);
	assign empty = fill_q == '0;
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

`default_nettype wire

@@ src/rsl_back.sv @@
// Back end: sector tables, current sector and the locate sequencer.
`default_nettype none

module rsl_back import rsl_pkg::*; #(
	parameter int MAX_SECTORS   = DEF_MAX_SECTORS,
	parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [SCOUNT_W-1:0] cfg_wdata,
	input  wire cmd_t                head,
	input  wire logic                empty,
	output logic                     pop,
	output logic                     clearing,
	output logic                     done,
	output out_item_t                result
);

	localparam int SIDX_W = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
	localparam int SCNT_W = $clog2(MAX_SECTORS + 1);
	localparam int NCNT_W = $clog2(MAX_NEIGHBORS + 1);
	localparam int NT_AW  = $clog2(MAX_SECTORS * MAX_NEIGHBORS);

	// Tables.
	bounds_t               bnd_mem [MAX_SECTORS];
	logic [NB_COUNT_W-1:0] cnt_mem [MAX_SECTORS];
	logic [IDX_W-1:0]      nt_mem  [MAX_SECTORS * MAX_NEIGHBORS];

	bounds_t               bnd_rd_q;
	logic [NB_COUNT_W-1:0] cnt_rd_q;
	logic [IDX_W-1:0]      nt_rd_q;

	// Control state.
	back_state_t         state_q, state_d;
	logic [SIDX_W-1:0]   cur_q, cur_d;
	logic                cur_vld_q, cur_vld_d;
	logic [SIDX_W-1:0]   clr_q, clr_d;
	logic [SCOUNT_W-1:0] sector_count_q;
	logic                done_q, done_d;
	logic                found_q, found_d;
	logic [IDX_W-1:0]    fidx_q;
	logic                cmp_vld_q, cmp_vld_d;

	// Sequencer data.
	logic signed [COORD_W-1:0] pos_x_q, pos_x_d;
	logic signed [COORD_W-1:0] pos_y_q, pos_y_d;
	logic [SCNT_W-1:0]         iss_q, iss_d;
	logic [SCNT_W-1:0]         n_all_q, n_all_d;
	logic [SIDX_W-1:0]         cmp_idx_q, cmp_idx_d;
	logic [NCNT_W-1:0]         nb_n_q, nb_n_d;
	logic [NCNT_W-1:0]         nb_j_q, nb_j_d;
	logic [NT_AW-1:0]          nb_base_q, nb_base_d;
	logic [SIDX_W-1:0]         nb_idx_q, nb_idx_d;

	// Memory ports.
	logic                  bnd_we;
	logic [SIDX_W-1:0]     bnd_waddr;
	logic [SIDX_W-1:0]     bnd_raddr;
	logic                  cnt_we;
	logic [SIDX_W-1:0]     cnt_waddr;
	logic [NB_COUNT_W-1:0] cnt_wdata;
	logic                  nt_we;
	logic [NT_AW-1:0]      nt_waddr;
	logic [NT_AW-1:0]      nt_raddr;

	// Widened index helpers.
	logic [31:0]       head_sidx_ext;
	logic [31:0]       nt_waddr_ext;
	logic [31:0]       nt_raddr_ext;
	logic [31:0]       nt_rd_ext;
	logic [31:0]       cnt_rd_ext;
	logic [31:0]       sc_ext;
	logic [31:0]       base_ext;
	logic [SIDX_W-1:0] res_idx;
	logic [31:0]       res_idx_ext;

	logic hit_strict;
	logic hit_incl;

	assign head_sidx_ext = 32'(head.sector_index);
	assign nt_waddr_ext  = head_sidx_ext * 32'(MAX_NEIGHBORS) + 32'(head.slot);
	assign nt_raddr_ext  = 32'(nb_base_q) + 32'(nb_j_q);
	assign nt_rd_ext     = 32'(nt_rd_q);
	assign cnt_rd_ext    = 32'(cnt_rd_q);
	assign sc_ext        = 32'(sector_count_q);
	assign base_ext      = 32'(cur_q) * 32'(MAX_NEIGHBORS);
	assign res_idx_ext   = 32'(res_idx);

	assign hit_strict = (pos_x_q > bnd_rd_q.x_low) && (pos_y_q > bnd_rd_q.y_low) &&
		(pos_x_q < bnd_rd_q.x_high) && (pos_y_q < bnd_rd_q.y_high);
	assign hit_incl = (pos_x_q >= bnd_rd_q.x_low) && (pos_y_q >= bnd_rd_q.y_low) &&
		(pos_x_q <= bnd_rd_q.x_high) && (pos_y_q <= bnd_rd_q.y_high);

	assign clearing            = state_q == ST_CLEAR;
	assign done                = done_q;
	assign result.sector_found = found_q;
	assign result.found_index  = fidx_q;

	always_comb begin
		state_d   = state_q;
		cur_d     = cur_q;
		cur_vld_d = cur_vld_q;
		clr_d     = clr_q;
		done_d    = 1'b0;
		found_d   = found_q;
		cmp_vld_d = cmp_vld_q;
		pos_x_d   = pos_x_q;
		pos_y_d   = pos_y_q;
		iss_d     = iss_q;
		n_all_d   = n_all_q;
		cmp_idx_d = cmp_idx_q;
		nb_n_d    = nb_n_q;
		nb_j_d    = nb_j_q;
		nb_base_d = nb_base_q;
		nb_idx_d  = nb_idx_q;
		res_idx   = '0;
		pop       = 1'b0;
		bnd_we    = 1'b0;
		bnd_waddr = head_sidx_ext[SIDX_W-1:0];
		bnd_raddr = cur_q;
		cnt_we    = 1'b0;
		cnt_waddr = head_sidx_ext[SIDX_W-1:0];
		cnt_wdata = NB_COUNT_W'(head.slot) + NB_COUNT_W'(1);
		nt_we     = 1'b0;
		nt_waddr  = nt_waddr_ext[NT_AW-1:0];
		nt_raddr  = nt_raddr_ext[NT_AW-1:0];
		case (state_q)
			ST_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_q;
				cnt_wdata = '0;
				clr_d     = clr_q + SIDX_W'(1);
				if (32'(clr_q) == MAX_SECTORS - 1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					case (head.op)
						OP_BOUNDS: begin
							bnd_we = 1'b1;
						end
						OP_NEIGHBOR: begin
							nt_we  = 1'b1;
							cnt_we = head.last;
						end
						OP_LOCATE: begin
							pos_x_d = head.bnd.x_low;
							pos_y_d = head.bnd.y_low;
							if (cur_vld_q) begin
								// Bounds and count of the current sector are read now.
								state_d = ST_CUR;
							end else begin
								iss_d     = '0;
								cmp_vld_d = 1'b0;
								n_all_d   = (sc_ext > 32'(MAX_SECTORS)) ?
									SCNT_W'(MAX_SECTORS) : SCNT_W'(sector_count_q);
								state_d   = ST_ALL;
							end
						end
						default: begin
							cur_vld_d = 1'b0;
							cur_d     = '0;
						end
					endcase
				end
			end
			ST_CUR: begin
				if (hit_strict) begin
					done_d  = 1'b1;
					found_d = 1'b1;
					res_idx = cur_q;
					state_d = ST_IDLE;
				end else begin
					nb_n_d    = (cnt_rd_ext > 32'(MAX_NEIGHBORS)) ?
						NCNT_W'(MAX_NEIGHBORS) : NCNT_W'(cnt_rd_q);
					nb_j_d    = '0;
					nb_base_d = base_ext[NT_AW-1:0];
					state_d   = ST_NB_RD;
				end
			end
			ST_NB_RD: begin
				if (nb_j_q == nb_n_q) begin
					cur_vld_d = 1'b0;
					cur_d     = '0;
					done_d    = 1'b1;
					found_d   = 1'b0;
					state_d   = ST_IDLE;
				end else begin
					state_d = ST_NB_IDX;
				end
			end
			ST_NB_IDX: begin
				// A neighbor entry naming a sector outside the table is skipped.
				if (nt_rd_ext < 32'(MAX_SECTORS)) begin
					bnd_raddr = nt_rd_ext[SIDX_W-1:0];
					nb_idx_d  = nt_rd_ext[SIDX_W-1:0];
					state_d   = ST_NB_CMP;
				end else begin
					nb_j_d  = nb_j_q + NCNT_W'(1);
					state_d = ST_NB_RD;
				end
			end
			ST_NB_CMP: begin
				if (hit_incl) begin
					cur_d   = nb_idx_q;
					done_d  = 1'b1;
					found_d = 1'b1;
					res_idx = nb_idx_q;
					state_d = ST_IDLE;
				end else begin
					nb_j_d  = nb_j_q + NCNT_W'(1);
					state_d = ST_NB_RD;
				end
			end
			ST_ALL: begin
				// Reads are issued back to back; each compare is made in the cycle after its read.
				bnd_raddr = iss_q[SIDX_W-1:0];
				if (cmp_vld_q && hit_strict) begin
					cur_d     = cmp_idx_q;
					cur_vld_d = 1'b1;
					done_d    = 1'b1;
					found_d   = 1'b1;
					res_idx   = cmp_idx_q;
					state_d   = ST_IDLE;
				end else if (iss_q < n_all_q) begin
					cmp_vld_d = 1'b1;
					cmp_idx_d = iss_q[SIDX_W-1:0];
					iss_d     = iss_q + SCNT_W'(1);
				end else begin
					done_d  = 1'b1;
					found_d = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			cur_q          <= '0;
			cur_vld_q      <= 1'b0;
			clr_q          <= '0;
			sector_count_q <= '0;
			done_q         <= 1'b0;
			found_q        <= 1'b0;
			cmp_vld_q      <= 1'b0;
		end else begin
			state_q   <= state_d;
			cur_q     <= cur_d;
			cur_vld_q <= cur_vld_d;
			clr_q     <= clr_d;
			done_q    <= done_d;
			found_q   <= found_d;
			cmp_vld_q <= cmp_vld_d;
			if (cfg_we) begin
				sector_count_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_x_q   <= pos_x_d;
		pos_y_q   <= pos_y_d;
		iss_q     <= iss_d;
		n_all_q   <= n_all_d;
		cmp_idx_q <= cmp_idx_d;
		nb_n_q    <= nb_n_d;
		nb_j_q    <= nb_j_d;
		nb_base_q <= nb_base_d;
		nb_idx_q  <= nb_idx_d;
		if (done_d) begin
			fidx_q <= res_idx_ext[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (bnd_we) begin
			bnd_mem[bnd_waddr] <= head.bnd;
		end
		bnd_rd_q <= bnd_mem[bnd_raddr];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		cnt_rd_q <= cnt_mem[cur_q];
	end

	always_ff @(posedge clk) begin
		if (nt_we) begin
			nt_mem[nt_waddr] <= head.neighbor_index;
		end
		nt_rd_q <= nt_mem[nt_raddr];
	end

endmodule

`default_nettype wire

@@ src/rectangle_sector_locator_core.sv @@
// Top level of the rectangle sector locator: front end, command queue and back end.
//
// Channel   Signals                 Handshake
// command   start, busy, cmd        beat taken when start is high and busy is low
// result    done, result            one-cycle strobe, always taken
// config    cfg_we, cfg_wdata       written at the edge where cfg_we is high
//
// The front end takes one beat a cycle while the two-entry queue has room and no clear runs.
// Loads and forgets are written as the back end pops them. A locate first checks its
// current sector; each neighbor checked then takes a table read, a bounds read and a
// compare, and running out of neighbors ends the search as not found.
// A full scan reads at most min(sector_count, MAX_SECTORS) sectors, one at a time through the
// single bounds read port.
// After reset, busy stays high while the neighbor counts are cleared.
// Results cannot be stalled by the receiver.
`default_nettype none

module rectangle_sector_locator_core import rsl_pkg::*; #(
	parameter int MAX_SECTORS   = DEF_MAX_SECTORS,
	parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire in_item_t            cmd,
	output logic                     done,
	output out_item_t                result,
	input  wire logic                cfg_we,
	input  wire logic [SCOUNT_W-1:0] cfg_wdata
);

	logic take;
	logic push;
	cmd_t entry;
	cmd_t head;
	logic full;
	logic empty;
	logic pop;
	logic clearing;

	assign busy = full || clearing;
	assign take = start && !busy;

	rsl_front #(
		.MAX_SECTORS  (MAX_SECTORS),
		.MAX_NEIGHBORS(MAX_NEIGHBORS)
	) u_front (
		.item (cmd),
		.take (take),
		.push (push),
		.entry(entry)
	);

	rsl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_entry(entry),
		.pop     (pop),
		.head    (head),
		.full    (full),
		.empty   (empty)
	);

	rsl_back #(
		.MAX_SECTORS  (MAX_SECTORS),
		.MAX_NEIGHBORS(MAX_NEIGHBORS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.clearing (clearing),
		.done     (done),
		.result   (result)
	);

endmodule

`default_nettype wire
